// ===== sv/srb_pkg.sv =====
package srb_pkg;

  // Framebuffer and region limits.
  localparam int FB_WIDTH   = 128;
  localparam int FB_HEIGHT  = 128;
  localparam int MAX_REGION = 1024;

  // Field widths fixed by the interface.
  localparam int COORD_W  = 12;
  localparam int SIZE_W   = 10;
  localparam int XFORM_W  = 3;
  localparam int ANCHOR_W = 7;
  localparam int ARGB_W   = 32;
  localparam int ADDR_W   = 14;
  localparam int ORIGIN_W = 13;
  localparam int POINT_W  = 14;
  localparam int WIDE_W   = 15;
  localparam int CFG_IDX_W = 3;

  // Framebuffer coordinate widths and the width of the linear index.
  localparam int FB_X_BITS = $clog2(FB_WIDTH);
  localparam int FB_Y_BITS = $clog2(FB_HEIGHT);
  localparam int LIN_W     = FB_Y_BITS + $clog2(FB_WIDTH + 1);

  // Anchor bits.
  localparam int ANC_HCENTER  = 0;
  localparam int ANC_VCENTER  = 1;
  localparam int ANC_RIGHT    = 3;
  localparam int ANC_BOTTOM   = 5;
  localparam int ANC_BASELINE = 6;

  // Orientation codes.
  localparam logic [XFORM_W-1:0] XF_NONE      = 3'd0;
  localparam logic [XFORM_W-1:0] XF_VMIRROR   = 3'd1;
  localparam logic [XFORM_W-1:0] XF_HMIRROR   = 3'd2;
  localparam logic [XFORM_W-1:0] XF_ROT180    = 3'd3;
  localparam logic [XFORM_W-1:0] XF_TRANSPOSE = 3'd4;
  localparam logic [XFORM_W-1:0] XF_ROT90     = 3'd5;
  localparam logic [XFORM_W-1:0] XF_ROT270    = 3'd6;
  localparam logic [XFORM_W-1:0] XF_ANTITRANS = 3'd7;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSLATE_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSLATE_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_W      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_H      = 3'd5;

  // Configuration as seen by the clip stage.
  typedef struct packed {
    logic signed [COORD_W-1:0] translate_x;
    logic signed [COORD_W-1:0] translate_y;
    logic signed [COORD_W-1:0] clip_x;
    logic signed [COORD_W-1:0] clip_y;
    logic        [COORD_W-1:0] clip_w;
    logic        [COORD_W-1:0] clip_h;
  } cfg_t;

  // A mapped pixel between the map stage and the clip stage.
  typedef struct packed {
    logic                      drawable;
    logic                      done;
    logic signed [POINT_W-1:0] ux;
    logic signed [POINT_W-1:0] uy;
    logic        [ARGB_W-1:0]  argb;
  } pix_t;

endpackage

// ===== sv/srb_map.sv =====
module srb_map (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              advance,
  input  logic                              in_valid,
  input  logic                              action,
  input  logic [srb_pkg::SIZE_W-1:0]        region_width,
  input  logic [srb_pkg::SIZE_W-1:0]        region_height,
  input  logic [srb_pkg::XFORM_W-1:0]       transform,
  input  logic [srb_pkg::ANCHOR_W-1:0]      anchor,
  input  logic signed [srb_pkg::COORD_W-1:0] anchor_x,
  input  logic signed [srb_pkg::COORD_W-1:0] anchor_y,
  input  logic [srb_pkg::ARGB_W-1:0]        pixel_argb,
  input  logic                              src_inside,
  output logic                              pix_valid,
  output srb_pkg::pix_t                     pix
);
  import srb_pkg::*;

  logic [SIZE_W-1:0]          saved_width;
  logic [SIZE_W-1:0]          saved_height;
  logic [XFORM_W-1:0]         saved_transform;
  logic signed [ORIGIN_W-1:0] origin_x;
  logic signed [ORIGIN_W-1:0] origin_y;
  logic [SIZE_W-1:0]          column_count;
  logic [SIZE_W-1:0]          row_count;

  logic [SIZE_W-1:0]          w_sat, h_sat, ow, oh;
  logic signed [ORIGIN_W-1:0] shift_x, shift_y;
  logic                       active, last_col;
  logic [SIZE_W-1:0]          col_inv, row_inv, ox, oy;
  pix_t                       pix_next;

  // Begin item: clamp the region and place the top-left origin.
  always_comb begin
    w_sat = region_width;
    h_sat = region_height;
    if (32'(region_width) > MAX_REGION) begin
      w_sat = SIZE_W'(MAX_REGION);
    end
    if (32'(region_height) > MAX_REGION) begin
      h_sat = SIZE_W'(MAX_REGION);
    end
    ow = transform[2] ? h_sat : w_sat;
    oh = transform[2] ? w_sat : h_sat;
    if (anchor[ANC_HCENTER]) begin
      shift_x = signed'(ORIGIN_W'(ow >> 1));
    end else if (anchor[ANC_RIGHT]) begin
      shift_x = signed'(ORIGIN_W'(ow));
    end else begin
      shift_x = '0;
    end
    if (anchor[ANC_VCENTER]) begin
      shift_y = signed'(ORIGIN_W'(oh >> 1));
    end else if (anchor[ANC_BOTTOM] || anchor[ANC_BASELINE]) begin
      shift_y = signed'(ORIGIN_W'(oh));
    end else begin
      shift_y = '0;
    end
  end

  // Pixel item: map the source position through the orientation.
  always_comb begin
    active   = (saved_width != '0) && (saved_height != '0) && (row_count < saved_height);
    last_col = ({1'b0, column_count} + 1'b1) >= {1'b0, saved_width};
    col_inv  = saved_width - SIZE_W'(1) - column_count;
    row_inv  = saved_height - SIZE_W'(1) - row_count;
    case (saved_transform)
      XF_VMIRROR: begin
        ox = column_count; oy = row_inv;
      end
      XF_HMIRROR: begin
        ox = col_inv; oy = row_count;
      end
      XF_ROT180: begin
        ox = col_inv; oy = row_inv;
      end
      XF_TRANSPOSE: begin
        ox = row_count; oy = column_count;
      end
      XF_ROT90: begin
        ox = row_inv; oy = column_count;
      end
      XF_ROT270: begin
        ox = row_count; oy = col_inv;
      end
      XF_ANTITRANS: begin
        ox = row_inv; oy = col_inv;
      end
      default: begin
        ox = column_count; oy = row_count;
      end
    endcase
    pix_next.drawable = active && src_inside && (pixel_argb[ARGB_W-1 -: 8] != 8'd0);
    pix_next.done     = active && (column_count == saved_width - SIZE_W'(1)) &&
                        (row_count == saved_height - SIZE_W'(1));
    pix_next.ux       = POINT_W'(origin_x) + signed'(POINT_W'(ox));
    pix_next.uy       = POINT_W'(origin_y) + signed'(POINT_W'(oy));
    pix_next.argb     = pixel_argb;
  end

  // Region state: begin latches geometry, pixels step the raster counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      saved_width     <= '0;
      saved_height    <= '0;
      saved_transform <= XF_NONE;
      origin_x        <= '0;
      origin_y        <= '0;
      column_count    <= '0;
      row_count       <= '0;
    end else if (advance && in_valid) begin
      if (!action) begin
        saved_width     <= w_sat;
        saved_height    <= h_sat;
        saved_transform <= transform;
        origin_x        <= ORIGIN_W'(anchor_x) - shift_x;
        origin_y        <= ORIGIN_W'(anchor_y) - shift_y;
        column_count    <= '0;
        row_count       <= '0;
      end else if (active) begin
        if (last_col) begin
          column_count <= '0;
          row_count    <= row_count + SIZE_W'(1);
        end else begin
          column_count <= column_count + SIZE_W'(1);
        end
      end
    end
  end

  // Stage register toward the clip stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (advance) begin
      pix_valid <= in_valid && action;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pix <= pix_next;
    end
  end

endmodule

// ===== sv/srb_clip.sv =====
module srb_clip (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  srb_pkg::cfg_t              cfg,
  input  logic                       pix_valid,
  input  srb_pkg::pix_t              pix,
  output logic                       out_valid,
  output logic                       write_enable,
  output logic [srb_pkg::ADDR_W-1:0] fb_address,
  output logic [srb_pkg::ARGB_W-1:0] write_data,
  output logic                       region_done
);
  import srb_pkg::*;

  logic signed [WIDE_W-1:0] ux, uy, clip_x_end, clip_y_end, fx, fy;
  logic                     in_clip, in_fb, we;
  logic [LIN_W-1:0]         lin;

  // Clip rectangle test, then translation and framebuffer bounds.
  always_comb begin
    ux         = WIDE_W'(pix.ux);
    uy         = WIDE_W'(pix.uy);
    clip_x_end = WIDE_W'(cfg.clip_x) + signed'(WIDE_W'(cfg.clip_w));
    clip_y_end = WIDE_W'(cfg.clip_y) + signed'(WIDE_W'(cfg.clip_h));
    in_clip    = (ux >= WIDE_W'(cfg.clip_x)) && (uy >= WIDE_W'(cfg.clip_y)) &&
                 (ux < clip_x_end) && (uy < clip_y_end);
    fx         = ux + WIDE_W'(cfg.translate_x);
    fy         = uy + WIDE_W'(cfg.translate_y);
    in_fb      = !fx[WIDE_W-1] && !fy[WIDE_W-1] &&
                 (fx < WIDE_W'(FB_WIDTH)) && (fy < WIDE_W'(FB_HEIGHT));
    we         = pix.drawable && in_clip && in_fb;
    lin        = LIN_W'(fy[FB_Y_BITS-1:0]) * LIN_W'(FB_WIDTH) +
                 LIN_W'(fx[FB_X_BITS-1:0]);
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      write_enable <= we;
      fb_address   <= we ? ADDR_W'(lin) : '0;
      write_data   <= we ? pix.argb : '0;
      region_done  <= pix.done;
    end
  end

endmodule

// ===== sv/sprite_region_blitter.sv =====
// Channel   Handshake             Payload
// input     in_valid / in_stall   action, region_width, region_height, transform,
//                                 anchor, anchor_x, anchor_y, pixel_argb, src_inside
// result    out_valid / out_stall write_enable, fb_address, write_data, region_done
// config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle while no result is held; the edge that accepts a pixel item loads the
// map register, and the result register is loaded from it when the pipeline next advances.
// Begin items update the region state and give no result.
// Reset is synchronous and clears the region state and both stage valids;
// the configuration registers return to zero translate and clip, 128 x 128 clip size.
// A stalled result holds both stages; in_stall follows out_stall while a result waits.
module sprite_region_blitter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               action,
  input  logic [srb_pkg::SIZE_W-1:0]         region_width,
  input  logic [srb_pkg::SIZE_W-1:0]         region_height,
  input  logic [srb_pkg::XFORM_W-1:0]        transform,
  input  logic [srb_pkg::ANCHOR_W-1:0]       anchor,
  input  logic signed [srb_pkg::COORD_W-1:0] anchor_x,
  input  logic signed [srb_pkg::COORD_W-1:0] anchor_y,
  input  logic [srb_pkg::ARGB_W-1:0]         pixel_argb,
  input  logic                               src_inside,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               write_enable,
  output logic [srb_pkg::ADDR_W-1:0]         fb_address,
  output logic [srb_pkg::ARGB_W-1:0]         write_data,
  output logic                               region_done,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [srb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [srb_pkg::COORD_W-1:0]        cfg_data
);
  import srb_pkg::*;

  cfg_t  cfg;
  logic  advance;
  logic  pix_valid;
  pix_t  pix;

  // The whole pipeline moves unless a finished result is being held.
  assign advance   = !(out_valid && out_stall);
  assign in_stall  = !advance;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.translate_x <= '0;
      cfg.translate_y <= '0;
      cfg.clip_x      <= '0;
      cfg.clip_y      <= '0;
      cfg.clip_w      <= COORD_W'(128);
      cfg.clip_h      <= COORD_W'(128);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TRANSLATE_X: cfg.translate_x <= signed'(cfg_data);
        CFG_TRANSLATE_Y: cfg.translate_y <= signed'(cfg_data);
        CFG_CLIP_X:      cfg.clip_x      <= signed'(cfg_data);
        CFG_CLIP_Y:      cfg.clip_y      <= signed'(cfg_data);
        CFG_CLIP_W:      cfg.clip_w      <= cfg_data;
        CFG_CLIP_H:      cfg.clip_h      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  srb_map u_map (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .in_valid      (in_valid),
    .action        (action),
    .region_width  (region_width),
    .region_height (region_height),
    .transform     (transform),
    .anchor        (anchor),
    .anchor_x      (anchor_x),
    .anchor_y      (anchor_y),
    .pixel_argb    (pixel_argb),
    .src_inside    (src_inside),
    .pix_valid     (pix_valid),
    .pix           (pix)
  );

  srb_clip u_clip (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .cfg          (cfg),
    .pix_valid    (pix_valid),
    .pix          (pix),
    .out_valid    (out_valid),
    .write_enable (write_enable),
    .fb_address   (fb_address),
    .write_data   (write_data),
    .region_done  (region_done)
  );

endmodule

// ===== dv/sprite_region_blitter_tb.sv =====
module sprite_region_blitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srb_pkg::*;

  // Item kinds on the input channel.
  localparam logic ACT_BEGIN = 1'b0;
  localparam logic ACT_PIXEL = 1'b1;

  // Anchor masks built from the bit positions in the package.
  localparam logic [ANCHOR_W-1:0] M_HCENTER  = ANCHOR_W'(1) << ANC_HCENTER;
  localparam logic [ANCHOR_W-1:0] M_VCENTER  = ANCHOR_W'(1) << ANC_VCENTER;
  localparam logic [ANCHOR_W-1:0] M_RIGHT    = ANCHOR_W'(1) << ANC_RIGHT;
  localparam logic [ANCHOR_W-1:0] M_BOTTOM   = ANCHOR_W'(1) << ANC_BOTTOM;
  localparam logic [ANCHOR_W-1:0] M_BASELINE = ANCHOR_W'(1) << ANC_BASELINE;
  localparam logic [ANCHOR_W-1:0] M_NONE     = '0;

  localparam int DRAIN_CYCLES    = 6;
  localparam int HOLD_OFF_CYCLES = 80;

  typedef struct packed {
    logic                      action;
    logic [SIZE_W-1:0]         width;
    logic [SIZE_W-1:0]         height;
    logic [XFORM_W-1:0]        xform;
    logic [ANCHOR_W-1:0]       anchor;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic [ARGB_W-1:0]         argb;
    logic                      src_in;
  } src_item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [ARGB_W-1:0] data;
    logic              done;
  } fb_write_t;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic                      action;
  logic [SIZE_W-1:0]         region_width;
  logic [SIZE_W-1:0]         region_height;
  logic [XFORM_W-1:0]        transform;
  logic [ANCHOR_W-1:0]       anchor;
  logic signed [COORD_W-1:0] anchor_x;
  logic signed [COORD_W-1:0] anchor_y;
  logic [ARGB_W-1:0]         pixel_argb;
  logic                      src_inside;
  logic                      out_valid;
  logic                      out_stall;
  logic                      write_enable;
  logic [ADDR_W-1:0]         fb_address;
  logic [ARGB_W-1:0]         write_data;
  logic                      region_done;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [COORD_W-1:0]        cfg_data;

  // Shadow of the block's registers and region state.
  int xlate_x = 0;
  int xlate_y = 0;
  int clip_left = 0;
  int clip_top = 0;
  int clip_width = 128;
  int clip_height = 128;
  int cur_w = 0;
  int cur_h = 0;
  logic [XFORM_W-1:0] cur_xform = XF_NONE;
  int org_x = 0;
  int org_y = 0;
  int col = 0;
  int row = 0;

  fb_write_t queued_writes[$];

  int items_sent = 0;
  int results_checked = 0;
  int writes_seen = 0;
  int regions_finished = 0;
  int mismatch_count = 0;

  bit source_pauses = 1'b1;
  bit sink_pauses = 1'b1;
  bit hold_off_request = 1'b0;

  sprite_region_blitter DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .region_width (region_width),
    .region_height(region_height),
    .transform    (transform),
    .anchor       (anchor),
    .anchor_x     (anchor_x),
    .anchor_y     (anchor_y),
    .pixel_argb   (pixel_argb),
    .src_inside   (src_inside),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .write_enable (write_enable),
    .fb_address   (fb_address),
    .write_data   (write_data),
    .region_done  (region_done),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short pauses, now and then a long one.
  function automatic int pause_length();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // Saturates a coordinate to the signed field range.
  function automatic logic signed [COORD_W-1:0] to_coord(int v);
    int hi;
    hi = (1 << (COORD_W - 1)) - 1;
    if (v > hi) v = hi;
    if (v < -hi - 1) v = -hi - 1;
    return COORD_W'(v);
  endfunction

  // Fields a begin item does not use are filled with noise.
  function automatic src_item_t make_begin(int w, int h, logic [XFORM_W-1:0] xf,
                                           logic [ANCHOR_W-1:0] anc, int ax, int ay);
    src_item_t it;
    it.action = ACT_BEGIN;
    it.width  = SIZE_W'(w);
    it.height = SIZE_W'(h);
    it.xform  = xf;
    it.anchor = anc;
    it.ax     = to_coord(ax);
    it.ay     = to_coord(ay);
    it.argb   = $urandom;
    it.src_in = 1'($urandom);
    return it;
  endfunction

  function automatic src_item_t make_pixel(logic [ARGB_W-1:0] argb, logic src_in);
    src_item_t it;
    it.action = ACT_PIXEL;
    it.width  = SIZE_W'($urandom);
    it.height = SIZE_W'($urandom);
    it.xform  = XFORM_W'($urandom);
    it.anchor = ANCHOR_W'($urandom);
    it.ax     = COORD_W'($urandom);
    it.ay     = COORD_W'($urandom);
    it.argb   = argb;
    it.src_in = src_in;
    return it;
  endfunction

  // Updates the region state for one item and queues the framebuffer write
  // that a pixel item should produce.
  task automatic predict_fb_write(input src_item_t it);
    int ow, oh, ox, oy, ux, uy, fx, fy;
    fb_write_t r;
    if (it.action == ACT_BEGIN) begin
      cur_w = (it.width > MAX_REGION) ? MAX_REGION : int'(it.width);
      cur_h = (it.height > MAX_REGION) ? MAX_REGION : int'(it.height);
      cur_xform = it.xform;
      ow = (it.xform >= XF_TRANSPOSE) ? cur_h : cur_w;
      oh = (it.xform >= XF_TRANSPOSE) ? cur_w : cur_h;
      if (it.anchor[ANC_HCENTER]) org_x = it.ax - ow / 2;
      else if (it.anchor[ANC_RIGHT]) org_x = it.ax - ow;
      else org_x = it.ax;
      if (it.anchor[ANC_VCENTER]) org_y = it.ay - oh / 2;
      else if (it.anchor[ANC_BOTTOM] || it.anchor[ANC_BASELINE]) org_y = it.ay - oh;
      else org_y = it.ay;
      col = 0;
      row = 0;
      return;
    end
    r = '0;
    if (cur_w != 0 && cur_h != 0 && row < cur_h) begin
      case (cur_xform)
        XF_VMIRROR:   begin ox = col;             oy = cur_h - 1 - row; end
        XF_HMIRROR:   begin ox = cur_w - 1 - col; oy = row;             end
        XF_ROT180:    begin ox = cur_w - 1 - col; oy = cur_h - 1 - row; end
        XF_TRANSPOSE: begin ox = row;             oy = col;             end
        XF_ROT90:     begin ox = cur_h - 1 - row; oy = col;             end
        XF_ROT270:    begin ox = row;             oy = cur_w - 1 - col; end
        XF_ANTITRANS: begin ox = cur_h - 1 - row; oy = cur_w - 1 - col; end
        default:      begin ox = col;             oy = row;             end
      endcase
      // Opaque pixels go through the clip rectangle, then the framebuffer bounds.
      if (it.src_in && it.argb[31:24] != 8'h00) begin
        ux = org_x + ox;
        uy = org_y + oy;
        if (ux >= clip_left && uy >= clip_top &&
            ux < clip_left + clip_width && uy < clip_top + clip_height) begin
          fx = ux + xlate_x;
          fy = uy + xlate_y;
          if (fx >= 0 && fy >= 0 && fx < FB_WIDTH && fy < FB_HEIGHT) begin
            r.we   = 1'b1;
            r.addr = ADDR_W'(fy * FB_WIDTH + fx);
            r.data = it.argb;
          end
        end
      end
      r.done = (col == cur_w - 1) && (row == cur_h - 1);
      col++;
      if (col >= cur_w) begin
        col = 0;
        row++;
      end
    end
    queued_writes.push_back(r);
  endtask

  // Offers one item, with an occasional pause before it, and records its
  // prediction at the edge where it is taken.
  task automatic send_item(input src_item_t it);
    if (source_pauses && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat (pause_length()) @(negedge clk);
    end
    in_valid      = 1'b1;
    action        = it.action;
    region_width  = it.width;
    region_height = it.height;
    transform     = it.xform;
    anchor        = it.anchor;
    anchor_x      = it.ax;
    anchor_y      = it.ay;
    pixel_argb    = it.argb;
    src_inside    = it.src_in;
    do @(posedge clk); while (in_stall);
    predict_fb_write(it);
    items_sent++;
    @(negedge clk);
  endtask

  // Lets every queued write come out, then gives the pipeline time to settle.
  task automatic wait_drain();
    in_valid = 1'b0;
    while (queued_writes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input int value);
    logic [COORD_W-1:0] bits;
    bits      = COORD_W'(value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = bits;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TRANSLATE_X: xlate_x = $signed(bits);
      CFG_TRANSLATE_Y: xlate_y = $signed(bits);
      CFG_CLIP_X:      clip_left = $signed(bits);
      CFG_CLIP_Y:      clip_top = $signed(bits);
      CFG_CLIP_W:      clip_width = int'(bits);
      CFG_CLIP_H:      clip_height = int'(bits);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // One region: mostly complete and small, sometimes huge, empty, cut short
  // or followed by stray pixels.
  task automatic random_region();
    int w, h, npix, ax, ay;
    source_pauses = ($urandom_range(0, 4) != 0);
    sink_pauses   = ($urandom_range(0, 4) != 0);
    case ($urandom_range(0, 19))
      0: begin w = $urandom_range(0, 1023); h = $urandom_range(0, 1023); end
      1: begin w = 0; h = $urandom_range(0, 4); end
      2: begin w = $urandom_range(0, 4); h = 0; end
      default: begin w = $urandom_range(1, 8); h = $urandom_range(1, 8); end
    endcase
    if ($urandom_range(0, 7) == 0) begin
      ax = int'($urandom_range(0, 4095)) - 2048;
      ay = int'($urandom_range(0, 4095)) - 2048;
    end else begin
      // Aim near the visible framebuffer so that most pixels land.
      ax = -xlate_x + int'($urandom_range(0, 170)) - 20;
      ay = -xlate_y + int'($urandom_range(0, 170)) - 20;
    end
    send_item(make_begin(w, h, XFORM_W'($urandom), ANCHOR_W'($urandom), ax, ay));
    if (w * h == 0) npix = $urandom_range(1, 3);
    else if (w * h > 64) npix = $urandom_range(1, 12);
    else npix = w * h;
    case ($urandom_range(0, 9))
      0: npix = $urandom_range(0, npix);
      1: npix += $urandom_range(1, 3);
      default: ;
    endcase
    repeat (npix) begin
      send_item(make_pixel(($urandom_range(0, 7) == 0) ? {8'h00, 24'($urandom)} : $urandom,
                           $urandom_range(0, 9) != 0));
    end
  endtask

  // Writes all six registers while idle, then runs random regions.
  task automatic run_phase(int tx, int ty, int cx, int cy, int cw, int ch, int n);
    int target;
    wait_drain();
    set_register(CFG_TRANSLATE_X, tx);
    set_register(CFG_TRANSLATE_Y, ty);
    set_register(CFG_CLIP_X, cx);
    set_register(CFG_CLIP_Y, cy);
    set_register(CFG_CLIP_W, cw);
    set_register(CFG_CLIP_H, ch);
    target = items_sent + n;
    while (items_sent < target) random_region();
  endtask

  // Pixels that arrive before any region has been opened.
  task automatic test_idle_pixels();
    send_item(make_pixel(32'hFF00_00FF, 1'b1));
    send_item(make_pixel(32'h8012_3456, 1'b1));
  endtask

  // Regions with zero width or zero height write nothing.
  task automatic test_empty_regions();
    send_item(make_begin(0, 5, XF_NONE, M_NONE, 10, 10));
    send_item(make_pixel(32'hFFFF_FFFF, 1'b1));
    send_item(make_begin(5, 0, XF_ROT180, M_NONE, 10, 10));
    send_item(make_pixel(32'hFFFF_FFFF, 1'b1));
  endtask

  // Field extremes, anchor precedence, minimal alpha, transparency and
  // the last framebuffer address.
  task automatic test_extreme_fields();
    send_item(make_begin(1023, 1023, XF_ANTITRANS, '1, 2047, -2048));
    send_item(make_pixel(32'hFFFF_FFFF, 1'b1));
    send_item(make_pixel(32'h0000_0000, 1'b1));
    send_item(make_begin(1023, 1, XF_NONE, M_RIGHT | M_BOTTOM, 1100, 50));
    send_item(make_pixel(32'h0100_0000, 1'b1));
    send_item(make_pixel(32'hFFFF_FFFF, 1'b0));
    send_item(make_begin(1, 1, XF_NONE, M_BASELINE, 127, 128));
    send_item(make_pixel(32'h80FF_FFFF, 1'b1));
    send_item(make_pixel(32'hFFFF_FFFF, 1'b1));
  endtask

  // A begin in the middle of a region restarts the counters.
  task automatic test_region_restart();
    send_item(make_begin(3, 2, XF_ROT90, M_HCENTER | M_VCENTER, 64, 64));
    send_item(make_pixel(32'hFF11_1111, 1'b1));
    send_item(make_pixel(32'hFF22_2222, 1'b0));
    send_item(make_pixel(32'hFF33_3333, 1'b1));
    send_item(make_begin(2, 2, XF_HMIRROR, M_NONE, 0, 0));
    repeat (4) send_item(make_pixel({8'hC0, 24'($urandom)}, 1'b1));
    send_item(make_pixel(32'hFFFF_FFFF, 1'b1));
  endtask

  // The receiver holds off long enough for the block to fill and stall its
  // input; the sender keeps offering, then waits for everything to drain.
  task automatic test_backpressure();
    source_pauses = 1'b0;
    sink_pauses   = 1'b0;
    hold_off_request = 1'b1;
    send_item(make_begin(6, 6, XF_ROT270, M_NONE, 40, 40));
    repeat (36) send_item(make_pixel({8'hFF, 24'($urandom)}, 1'b1));
    wait_drain();
    source_pauses = 1'b1;
    sink_pauses   = 1'b1;
  endtask

  task automatic test_random_blits();
    run_phase(0, 0, 0, 0, 128, 128, 300);
    run_phase(12, -7, 4, 3, 100, 90, 300);
    run_phase(-2048, 2047, -2048, -2048, 4095, 4095, 200);
    run_phase(2047, -2048, 2047, 2047, 0, 0, 100);
    run_phase(-30, 40, -20, 10, 60, 4095, 300);
    run_phase(5, 5, -5, -5, 4095, 140, 300);
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : result_sink
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        out_stall = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else if (sink_pauses && $urandom_range(0, 3) == 0) begin
        out_stall = 1'b1;
        repeat (pause_length()) @(negedge clk);
      end else begin
        out_stall = 1'b0;
        @(negedge clk);
      end
    end
  end

  // Compares every accepted result with the oldest queued write.
  always @(posedge clk) begin : result_check
    fb_write_t want;
    if (!rst && out_valid && !out_stall) begin
      if (queued_writes.size() == 0) begin
        $display("%0t: unexpected result: expected none, got we %b addr %h data %h done %b",
                 $time, write_enable, fb_address, write_data, region_done);
        mismatch_count++;
      end else begin
        want = queued_writes.pop_front();
        results_checked++;
        if (write_enable !== want.we) begin
          $display("%0t: write_enable expected %b, got %b", $time, want.we, write_enable);
          mismatch_count++;
        end
        if (fb_address !== want.addr) begin
          $display("%0t: fb_address expected %h, got %h", $time, want.addr, fb_address);
          mismatch_count++;
        end
        if (write_data !== want.data) begin
          $display("%0t: write_data expected %h, got %h", $time, want.data, write_data);
          mismatch_count++;
        end
        if (region_done !== want.done) begin
          $display("%0t: region_done expected %b, got %b", $time, want.done, region_done);
          mismatch_count++;
        end
        if (want.we) writes_seen++;
        if (want.done) regions_finished++;
      end
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    rst           = 1'b1;
    in_valid      = 1'b0;
    action        = ACT_BEGIN;
    region_width  = '0;
    region_height = '0;
    transform     = XF_NONE;
    anchor        = M_NONE;
    anchor_x      = '0;
    anchor_y      = '0;
    pixel_argb    = '0;
    src_inside    = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_TRANSLATE_X;
    cfg_data      = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_idle_pixels();
    test_empty_regions();
    test_extreme_fields();
    test_region_restart();
    test_backpressure();
    test_random_blits();
    wait_drain();

    $display("Sent %0d items over six clip and translate settings; %0d results checked.",
             items_sent, results_checked);
    $display("Saw %0d framebuffer writes and %0d finished regions, with one long hold-off.",
             writes_seen, regions_finished);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
